@@ design/csc_pkg.sv @@
// Shared constants and types for the CSV structure checker.
package csc_pkg;

	localparam int LANES  = 8;
	localparam int SLOTS  = 2 * LANES;
	localparam int CNT_W  = $clog2(LANES + 1);
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	localparam logic [7:0] QUOTE_BYTE = 8'h22;
	localparam logic [7:0] LF_BYTE    = 8'h0A;
	localparam logic [7:0] CR_BYTE    = 8'h0D;

	localparam logic [1:0] ISSUE_FIELDS      = 2'd0;
	localparam logic [1:0] ISSUE_MISSING_CR  = 2'd1;
	localparam logic [1:0] ISSUE_UNWANTED_CR = 2'd2;

	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_EXPECTED  = 2'd1;
	localparam logic [1:0] REG_REQ_CR    = 2'd2;

	localparam logic [7:0]  DELIMITER_RST = 8'd44;
	localparam logic [15:0] EXPECTED_RST  = 16'd1;

	typedef struct packed {
		logic             lf_unq;
		logic             has_lf_before;
		logic [CNT_W-1:0] seg_cnt;
		logic [CNT_W-1:0] lf_before;
		logic [7:0]       prev_byte;
		logic             prev_valid;
	} lane_in_t;

	typedef struct packed {
		logic        mismatch;
		logic        cr_bad;
		logic [1:0]  cr_kind;
		logic [15:0] fields;
		logic [31:0] row;
	} lane_out_t;

endpackage

@@ design/csc_in_if.sv @@
// Input channel: one eight-byte text chunk per transaction.
interface csc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] chunk_bytes;
	logic        last_chunk;

	modport source (output valid, output chunk_bytes, output last_chunk, input ready);
	modport sink (input valid, input chunk_bytes, input last_chunk, output ready);
endinterface

@@ design/csc_out_if.sv @@
// Output channel: one reported issue per transaction.
interface csc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  issue_kind;
	logic [31:0] row_number;
	logic [15:0] fields_seen;
	logic [2:0]  byte_lane;
	logic        last;

	modport source (output valid, output issue_kind, output row_number, output fields_seen,
		output byte_lane, output last, input ready);
	modport sink (input valid, input issue_kind, input row_number, input fields_seen,
		input byte_lane, input last, output ready);
endinterface

@@ design/csc_lane.sv @@
// One byte lane: field count, row number and line-ending checks at a linefeed.
module csc_lane (
	input  csc_pkg::lane_in_t  lin,
	input  logic [15:0]        field_count,
	input  logic [31:0]        row_count,
	input  logic [15:0]        expected_fields,
	input  logic               require_cr,
	output csc_pkg::lane_out_t lout
);
	import csc_pkg::*;

	logic [16:0] fsum;
	logic [32:0] rsum;
	logic        had_cr;

	assign fsum   = {1'b0, lin.has_lf_before ? 16'd0 : field_count} + 17'(lin.seg_cnt);
	assign rsum   = {1'b0, row_count} + 33'(lin.lf_before);
	assign had_cr = (lin.prev_byte == CR_BYTE);

	always_comb begin
		lout.fields   = fsum[16] ? 16'hFFFF : fsum[15:0];
		lout.row      = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
		lout.mismatch = lin.lf_unq && (lout.fields != expected_fields);
		lout.cr_bad   = lin.lf_unq && lin.prev_valid && (require_cr != had_cr);
		lout.cr_kind  = require_cr ? ISSUE_MISSING_CR : ISSUE_UNWANTED_CR;
	end
endmodule

@@ design/csc_merge.sv @@
// Issue bank: holds one chunk's lane findings and sends them out in byte order.
module csc_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  csc_pkg::lane_out_t lanes [csc_pkg::LANES],
	output logic               in_ready,
	csc_out_if.source          issue
);
	import csc_pkg::*;

	logic [SLOTS-1:0]  pend_q;
	logic [SLOTS-1:0]  low;
	logic [SLOTS-1:0]  rest;
	logic [SLOTS-1:0]  new_mask;
	logic [15:0]       fields_q [LANES];
	logic [31:0]       row_q [LANES];
	logic [1:0]        crk_q [LANES];
	logic [LANE_W-1:0] sel_lane;
	logic              sel_cr;
	logic              drain;

	assign low      = pend_q & (~pend_q + SLOTS'(1));
	assign rest     = pend_q & ~low;
	assign drain    = issue.valid && issue.ready;
	assign in_ready = (pend_q == '0) || ((rest == '0) && issue.ready);

	always_comb begin
		sel_lane = '0;
		sel_cr   = 1'b0;
		for (int s = 0; s < SLOTS; s++) begin
			if (low[s]) begin
				sel_lane = LANE_W'(s / 2);
				sel_cr   = (s % 2) == 1;
			end
		end
		for (int k = 0; k < LANES; k++) begin
			new_mask[2*k]   = lanes[k].mismatch;
			new_mask[2*k+1] = lanes[k].cr_bad;
		end
	end

	assign issue.valid       = (pend_q != '0);
	assign issue.issue_kind  = sel_cr ? crk_q[sel_lane] : ISSUE_FIELDS;
	assign issue.row_number  = row_q[sel_lane];
	assign issue.fields_seen = fields_q[sel_lane];
	assign issue.byte_lane   = 3'(sel_lane);
	assign issue.last        = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= new_mask;
		end else if (drain) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < LANES; k++) begin
				fields_q[k] <= lanes[k].fields;
				row_q[k]    <= lanes[k].row;
				crk_q[k]    <= lanes[k].cr_kind;
			end
		end
	end
endmodule

@@ design/csv_structure_checker_unit.sv @@
// Top level: APB registers, quote/field scan across lanes, issue bank.
// Latency: a chunk's issues appear the cycle after it is taken, one per ready cycle.
// Throughput: one chunk per cycle while each chunk causes at most one issue and the
// output is ready; a chunk with more issues stalls input while the issue bank drains.
// Reset: arst_n clears scan state, counters, pending issues and registers to defaults.
module csv_structure_checker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	csc_in_if.sink      chunk,
	csc_out_if.source   issue
);
	import csc_pkg::*;

	logic [7:0]       delimiter_q;
	logic [15:0]      expected_q;
	logic             req_cr_q;
	logic             quote_q;
	logic [15:0]      fc_q;
	logic [31:0]      row_q;
	logic [7:0]       prev_q;
	logic             pvalid_q;
	lane_in_t         lin [LANES];
	lane_out_t        lout [LANES];
	logic             quote_end;
	logic [CNT_W-1:0] cnt_end;
	logic [CNT_W-1:0] lf_total;
	logic             has_lf_end;
	logic [16:0]      fc_sum;
	logic [32:0]      row_sum;
	logic             accept;
	logic             wr;
	logic             in_ready;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign accept = chunk.valid && chunk.ready;
	assign chunk.ready = in_ready;

	always_comb begin
		unique case (paddr[3:2])
			REG_DELIMITER: prdata = {24'd0, delimiter_q};
			REG_EXPECTED:  prdata = {16'd0, expected_q};
			REG_REQ_CR:    prdata = {31'd0, req_cr_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIMITER_RST;
			expected_q  <= EXPECTED_RST;
			req_cr_q    <= 1'b0;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_DELIMITER: delimiter_q <= pwdata[7:0];
				REG_EXPECTED:  expected_q  <= pwdata[15:0];
				REG_REQ_CR:    req_cr_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// quote prefix and per-lane segment counts
	always_comb begin
		logic             q;
		logic [CNT_W-1:0] cnt;
		logic [CNT_W-1:0] nlf;
		logic             has_lf;
		logic [7:0]       b;
		logic [7:0]       pb;
		logic             pv;
		logic             lfu;
		logic             ev;
		q      = quote_q;
		cnt    = '0;
		nlf    = '0;
		has_lf = 1'b0;
		pb     = prev_q;
		pv     = pvalid_q;
		for (int k = 0; k < LANES; k++) begin
			b = chunk.chunk_bytes[8*k +: 8];
			if (b == QUOTE_BYTE)
				q = ~q;
			lfu = !q && (b == LF_BYTE);
			ev  = !q && ((b == delimiter_q) || (b == LF_BYTE));
			cnt = cnt + CNT_W'(ev);
			lin[k].lf_unq        = lfu;
			lin[k].has_lf_before = has_lf;
			lin[k].seg_cnt       = cnt;
			lin[k].lf_before     = nlf;
			lin[k].prev_byte     = pb;
			lin[k].prev_valid    = pv;
			if (lfu) begin
				cnt    = '0;
				has_lf = 1'b1;
				nlf    = nlf + CNT_W'(1);
			end
			pb = b;
			pv = 1'b1;
		end
		quote_end  = q;
		cnt_end    = cnt;
		lf_total   = nlf;
		has_lf_end = has_lf;
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		csc_lane u_lane (
			.lin             (lin[g]),
			.field_count     (fc_q),
			.row_count       (row_q),
			.expected_fields (expected_q),
			.require_cr      (req_cr_q),
			.lout            (lout[g])
		);
	end

	assign fc_sum  = {1'b0, fc_q} + 17'(cnt_end);
	assign row_sum = {1'b0, row_q} + 33'(lf_total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q  <= 1'b0;
			fc_q     <= '0;
			row_q    <= '0;
			prev_q   <= '0;
			pvalid_q <= 1'b0;
		end else if (accept) begin
			quote_q  <= quote_end;
			fc_q     <= has_lf_end ? 16'(cnt_end) : (fc_sum[16] ? 16'hFFFF : fc_sum[15:0]);
			row_q    <= row_sum[32] ? 32'hFFFF_FFFF : row_sum[31:0];
			prev_q   <= chunk.chunk_bytes[8*LANES-1 -: 8];
			pvalid_q <= !chunk.last_chunk;
		end
	end

	csc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.lanes    (lout),
		.in_ready (in_ready),
		.issue    (issue)
	);
endmodule
